// ===== rtl/core/aadf_pkg.sv =====
// Package: shared types and constants for the aircraft alert dedup filter.
package aadf_pkg;

    localparam int SEEN_DEPTH_DEF     = 32;
    localparam int WATCH_DEPTH_DEF    = 16;
    localparam int CALLSIGN_CHARS_DEF = 8;

    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    localparam logic [1:0] OP_CHECK = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    localparam logic [7:0] REG_MIL_EN = 8'd0;
    localparam logic [7:0] REG_EMG_EN = 8'd1;

    typedef struct packed {
        logic [1:0]  operation;
        logic [63:0] callsign_chars;
        logic        is_military;
        logic        is_emergency;
        logic        last_in_batch;
    } t_item;

    typedef struct packed {
        logic        highlighted;
        logic        new_alert;
        logic        watch_match;
        logic        buzz;
        logic        watch_accepted;
        logic [4:0]  watch_entries_used;
        logic [31:0] callsign_hash;
    } t_result;

    typedef struct packed {
        logic        done;
        logic        valid;
        logic [31:0] hash;
        logic [63:0] norm;
    } t_char_res;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CHARS, ST_DECIDE, ST_WRD, ST_WCMP, ST_POST, ST_SRD, ST_SCMP
    } t_state;

endpackage

// ===== rtl/core/aadf_char_unit.sv =====
// Byte-serial FNV-1a hash, normalisation and validity check of one callsign.
module aadf_char_unit import aadf_pkg::*; #(
    parameter int CALLSIGN_CHARS = CALLSIGN_CHARS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_cs,
    output t_char_res   o_res
);
    localparam int LW = $clog2(CALLSIGN_CHARS + 1);

    logic          r_run, n_run;
    logic          r_done;
    logic [LW-1:0] r_k, r_n;
    logic          r_term;
    logic [63:0]   r_cs, r_norm;
    logic [31:0]   r_hash;
    logic [7:0]    c, up;
    logic          ws, lane_ok;

    assign c  = r_cs[7:0];
    assign ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    assign up = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    assign n_run = r_run && (r_k != LW'(CALLSIGN_CHARS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_run && !n_run;
            r_run  <= i_start ? 1'b1 : n_run;
        end
        if (i_start) begin
            r_k    <= '0;
            r_n    <= '0;
            r_term <= 1'b0;
            r_cs   <= i_cs;
            r_norm <= '0;
            r_hash <= FNV_BASIS;
        end else if (r_run) begin
            r_k  <= r_k + LW'(1);
            r_cs <= r_cs >> 8;
            if (c == 8'h00) begin
                r_term <= 1'b1;
            end else if (!r_term) begin
                r_hash <= 32'((r_hash ^ {24'h0, c}) * FNV_PRIME);
                if (!ws) begin
                    r_norm[8*r_n +: 8] <= up;
                    r_n <= r_n + LW'(1);
                end
            end
        end
    end

    always_comb begin
        lane_ok = (r_n >= LW'(4));
        for (int k = 0; k < CALLSIGN_CHARS; k++) begin
            if (LW'(k) < r_n) begin
                if (k < 3) begin
                    if (!(r_norm[8*k +: 8] >= 8'h41 && r_norm[8*k +: 8] <= 8'h5A))
                        lane_ok = 1'b0;
                end else if (!((r_norm[8*k +: 8] >= 8'h41 && r_norm[8*k +: 8] <= 8'h5A)
                            || (r_norm[8*k +: 8] >= 8'h30 && r_norm[8*k +: 8] <= 8'h39))) begin
                    lane_ok = 1'b0;
                end
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.valid = lane_ok;
    assign o_res.hash  = r_hash;
    assign o_res.norm  = r_norm;
endmodule

// ===== rtl/core/aircraft_alert_dedup_filter_core.sv =====
// Top level: sequencer, watchlist store and recent-hash ring of the alert filter.
// Usage: raise start with a word on i_item while busy is low; the word is taken
// at that edge and busy stays high until the result word appears on o_result
// for exactly one cycle, flagged by o_result_valid. The receiver cannot stall.
// Sequence: the byte-serial FNV-1a hash over CALLSIGN_CHARS bytes, then a scan
// of the watchlist, one read and one compare state per entry (stops at a match),
// then a scan of the ring when the item alerts (stops at a hit), then the result.
// One item at a time; a new word is taken only while busy is low.
// Configuration: i_cfg_valid with i_cfg_index/i_cfg_data, always ready; index 0
// is the military enable, 1 the emergency enable, others ignored. Write only
// when idle.
// Reset (synchronous, active low) clears enables, the watchlist count, the ring
// valid bits and pointer and the batch flag; no clearing pass is needed.
module aircraft_alert_dedup_filter_core import aadf_pkg::*; #(
    parameter int SEEN_DEPTH     = SEEN_DEPTH_DEF,
    parameter int WATCH_DEPTH    = WATCH_DEPTH_DEF,
    parameter int CALLSIGN_CHARS = CALLSIGN_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_item      i_item,
    output logic       busy,
    output t_result    o_result,
    output logic       o_result_valid,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    localparam int SW  = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;
    localparam int WIW = (WATCH_DEPTH > 1) ? $clog2(WATCH_DEPTH) : 1;
    localparam int CW  = $clog2(WATCH_DEPTH + 1);

    t_state          r_state, n_state;
    t_item           r_item;
    t_char_res       cres;
    logic            r_cfg_mil, r_cfg_emg;
    logic [CW-1:0]   r_wcount;
    logic [WIW-1:0]  r_widx;
    logic [SW-1:0]   r_sidx, r_wptr;
    logic            r_found, r_hit, r_hl, r_batch;
    logic [SEEN_DEPTH-1:0] r_svalid;
    logic [63:0]     watch_mem [WATCH_DEPTH];
    logic [31:0]     seen_mem  [SEEN_DEPTH];
    logic [63:0]     r_wrd;
    logic [31:0]     r_srd;
    t_result         r_out;
    logic            r_out_v;

    logic is_check, is_add, active, scan_w, last_w, hit_now, last_s, found_now;
    logic fresh, acc, finish;

    aadf_char_unit #(.CALLSIGN_CHARS(CALLSIGN_CHARS)) u_char (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_cs    (i_item.callsign_chars),
        .o_res   (cres)
    );

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_result    = r_out;
    assign o_result_valid = r_out_v;

    assign is_check  = (r_item.operation == OP_CHECK);
    assign is_add    = (r_item.operation == OP_ADD);
    assign active    = r_cfg_mil || r_cfg_emg || (r_wcount != '0);
    assign scan_w    = cres.valid && (r_wcount != '0) && ((is_check && active) || is_add);
    assign found_now = (r_wrd == cres.norm);
    assign last_w    = (CW'(r_widx) + CW'(1) == r_wcount);
    assign hit_now   = r_svalid[r_sidx] && (r_srd == cres.hash);
    assign last_s    = (r_sidx == SW'(SEEN_DEPTH - 1));
    // the hit of the final compare is not registered yet when the item ends
    assign fresh     = r_hl && !(r_hit || hit_now);
    assign acc       = is_add && cres.valid && !r_found && (r_wcount < CW'(WATCH_DEPTH));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (start) n_state = ST_CHARS;
            ST_CHARS:  if (cres.done) n_state = ST_DECIDE;
            ST_DECIDE: n_state = scan_w ? ST_WRD : ST_POST;
            ST_WRD:    n_state = ST_WCMP;
            ST_WCMP:   n_state = (found_now || last_w) ? ST_POST : ST_WRD;
            ST_POST:   n_state = r_hl ? ST_SRD : ST_IDLE;
            ST_SRD:    n_state = ST_SCMP;
            ST_SCMP:   n_state = (hit_now || last_s) ? ST_IDLE : ST_SRD;
            default:   n_state = ST_IDLE;
        endcase
    end

    // completion of an item
    always_comb begin
        case (r_state)
            ST_POST: finish = !r_hl;
            ST_SCMP: finish = hit_now || last_s;
            default: finish = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_cfg_mil <= 1'b0;
            r_cfg_emg <= 1'b0;
            r_wcount  <= '0;
            r_wptr    <= '0;
            r_svalid  <= '0;
            r_batch   <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_out_v <= finish;
            if (i_cfg_valid && i_cfg_index == REG_MIL_EN) r_cfg_mil <= i_cfg_data[0];
            if (i_cfg_valid && i_cfg_index == REG_EMG_EN) r_cfg_emg <= i_cfg_data[0];
            if (finish) begin
                if (fresh) begin
                    r_svalid[r_wptr] <= 1'b1;
                    r_wptr <= (r_wptr == SW'(SEEN_DEPTH - 1)) ? '0 : r_wptr + SW'(1);
                end
                if (is_check && r_item.last_in_batch) r_batch <= 1'b0;
                else if (fresh) r_batch <= 1'b1;
                if (acc) r_wcount <= r_wcount + CW'(1);
                else if (r_item.operation == OP_CLEAR) r_wcount <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) r_item <= i_item;
        case (r_state)
            ST_DECIDE: begin
                r_widx  <= '0;
                r_found <= 1'b0;
                r_hit   <= 1'b0;
            end
            ST_WRD: r_wrd <= watch_mem[r_widx];
            ST_WCMP: begin
                r_found <= found_now;
                r_widx  <= r_widx + WIW'(1);
            end
            ST_POST: begin
                r_sidx <= '0;
            end
            ST_SRD: r_srd <= seen_mem[r_sidx];
            ST_SCMP: begin
                r_hit  <= hit_now;
                r_sidx <= r_sidx + SW'(1);
            end
            default: ;
        endcase
        if (r_state == ST_DECIDE)
            r_hl <= is_check && active &&
                    ((r_cfg_mil && r_item.is_military) || (r_cfg_emg && r_item.is_emergency));
        else if (r_state == ST_WCMP && found_now && is_check)
            r_hl <= 1'b1;
        if (finish && fresh) seen_mem[r_wptr] <= cres.hash;
        if (finish && acc) watch_mem[r_wcount[WIW-1:0]] <= cres.norm;
        if (finish) begin
            r_out.highlighted        <= r_hl;
            r_out.new_alert          <= fresh;
            r_out.watch_match        <= is_check && r_found;
            r_out.buzz               <= is_check && r_item.last_in_batch && (r_batch || fresh);
            r_out.watch_accepted     <= acc;
            r_out.watch_entries_used <= acc ? 5'(r_wcount + CW'(1))
                                      : (r_item.operation == OP_CLEAR) ? 5'd0 : 5'(r_wcount);
            r_out.callsign_hash      <= cres.hash;
        end
    end
endmodule

// ===== rtl/core/aadf_checker.sv =====
// Port-level checker for the alert filter core, bound to the top level.
module aadf_checker import aadf_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_result o_result,
    input logic    o_result_valid
);
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("busy not raised");
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy)) else $error("result without work");
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid) else $error("double result");
    a_new_implies_hl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.new_alert) |-> o_result.highlighted)
        else $error("new alert not highlighted");
    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.watch_accepted) |-> (o_result.watch_entries_used != 5'd0))
        else $error("accepted but empty");
endmodule

bind aircraft_alert_dedup_filter_core aadf_checker u_aadf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result       (o_result),
    .o_result_valid (o_result_valid)
);

// ===== tb/sv/aircraft_alert_dedup_filter_core_test.sv =====
// Testbench for the aircraft alert dedup filter: directed table, then random words, checked by a predictor.
module aircraft_alert_dedup_filter_core_test;
    import aadf_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH  = 32;
    localparam int WATCH_SLOTS = 16;
    localparam int NAME_BYTES  = 8;
    localparam int RANDOM_WORDS = 1800;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start = 1'b0;
    t_item      i_item = '0;
    logic       busy;
    t_result    o_result;
    logic       o_result_valid;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_index = '0;
    logic [7:0] i_cfg_data = '0;

    aircraft_alert_dedup_filter_core dut (.*);

    always #2 i_clk = ~i_clk;

    // predictor state
    logic [63:0] watch_names[WATCH_SLOTS];
    int          watch_used;
    logic [31:0] recent_hash[RING_DEPTH];
    bit          recent_ok[RING_DEPTH];
    int          ring_ptr;
    bit          batch_flag;
    bit          mil_en, emg_en;

    t_result pending_results[$];
    int      mismatches = 0;

    string callsign_pool[24] = '{"BAW123", "DLH4", "RCH871", "AFR99A", "UAL1234",
        "KLM7", "EZY88ZZ", "SWA2020", "NAV0", "QTR1", "CNV4410", "RRR9",
        "SAM01", "ACA876", "DAL55", "JBU3X", "THY1Y", "AAL100", "FDX12", "UPS5",
        "GAF618", "IAM42", "BOXER1", "ZZZZ9999"};

    function automatic logic [31:0] fnv1a(logic [63:0] cs);
        logic [31:0] h;
        h = FNV_BASIS;
        for (int k = 0; k < NAME_BYTES; k++) begin
            if (cs[8*k +: 8] == 8'h00) break;
            h = (h ^ {24'h0, cs[8*k +: 8]}) * FNV_PRIME;
        end
        return h;
    endfunction

    function automatic logic [63:0] fold_callsign(logic [63:0] cs, output int len);
        logic [63:0] r;
        logic [7:0]  c;
        r = '0;
        len = 0;
        for (int k = 0; k < NAME_BYTES; k++) begin
            c = cs[8*k +: 8];
            if (c == 8'h00) break;
            if (c == 8'h20 || (c >= 8'h09 && c <= 8'h0D)) continue;
            if (c >= "a" && c <= "z") c = c - 8'h20;
            r[8*len +: 8] = c;
            len++;
        end
        return r;
    endfunction

    function automatic bit callsign_ok(logic [63:0] n, int len);
        logic [7:0] c;
        if (len < 4 || len > NAME_BYTES) return 0;
        for (int k = 0; k < len; k++) begin
            c = n[8*k +: 8];
            if (k < 3) begin
                if (!((c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))) return 0;
            end else if (!((c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))) begin
                return 0;
            end
        end
        return 1;
    endfunction

    function automatic bit on_watchlist(logic [63:0] n);
        for (int i = 0; i < watch_used; i++)
            if (watch_names[i] == n) return 1;
        return 0;
    endfunction

    function automatic t_result predict_alert(t_item it);
        t_result     r;
        logic [63:0] n;
        int          len;
        bit          seen;
        r = '0;
        r.callsign_hash = fnv1a(it.callsign_chars);
        n = fold_callsign(it.callsign_chars, len);
        if (it.operation == OP_CHECK) begin
            if (mil_en || emg_en || watch_used > 0) begin
                r.watch_match = watch_used > 0 && callsign_ok(n, len) && on_watchlist(n);
                r.highlighted = (mil_en && it.is_military) || (emg_en && it.is_emergency)
                                || r.watch_match;
                seen = 0;
                for (int i = 0; i < RING_DEPTH; i++)
                    if (recent_ok[i] && recent_hash[i] == r.callsign_hash) seen = 1;
                if (r.highlighted && !seen) begin
                    recent_hash[ring_ptr] = r.callsign_hash;
                    recent_ok[ring_ptr] = 1;
                    ring_ptr = (ring_ptr + 1) % RING_DEPTH;
                    r.new_alert = 1;
                    batch_flag = 1;
                end
            end
            if (it.last_in_batch) begin
                r.buzz = batch_flag;
                batch_flag = 0;
            end
        end else if (it.operation == OP_ADD) begin
            if (callsign_ok(n, len) && !on_watchlist(n) && watch_used < WATCH_SLOTS) begin
                watch_names[watch_used] = n;
                watch_used++;
                r.watch_accepted = 1;
            end
        end else if (it.operation == OP_CLEAR) begin
            watch_used = 0;
        end
        r.watch_entries_used = 5'(watch_used);
        return r;
    endfunction

    function automatic logic [63:0] pack_name(string s);
        logic [63:0] v;
        v = '0;
        for (int k = 0; k < s.len() && k < NAME_BYTES; k++) v[8*k +: 8] = s[k];
        return v;
    endfunction

    // result monitor
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_result_valid) begin
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", o_result);
            end else begin
                e = pending_results.pop_front();
                if (o_result.highlighted !== e.highlighted
                        || o_result.new_alert !== e.new_alert
                        || o_result.watch_match !== e.watch_match
                        || o_result.buzz !== e.buzz
                        || o_result.watch_accepted !== e.watch_accepted
                        || o_result.watch_entries_used !== e.watch_entries_used
                        || o_result.callsign_hash !== e.callsign_hash) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: hl/new/match/buzz/acc/used/hash exp %b%b%b%b%b %0d %h got %b%b%b%b%b %0d %h",
                            e.highlighted, e.new_alert, e.watch_match, e.buzz,
                            e.watch_accepted, e.watch_entries_used, e.callsign_hash,
                            o_result.highlighted, o_result.new_alert, o_result.watch_match,
                            o_result.buzz, o_result.watch_accepted,
                            o_result.watch_entries_used, o_result.callsign_hash);
                end
            end
        end
    end

    task automatic drain();
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (120) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_MIL_EN) mil_en = val[0];
        else if (idx == REG_EMG_EN) emg_en = val[0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_enables(bit m, bit e);
        drain();
        write_reg(REG_MIL_EN, {7'($urandom_range(127, 0)), m});
        write_reg(REG_EMG_EN, {7'($urandom_range(127, 0)), e});
        write_reg(8'hFF, 8'hFF);
    endtask

    task automatic send_word(t_item it, bit typed, t_result want);
        t_result p;
        int gap;
        gap = $urandom_range(99, 0);
        if (gap >= 95) repeat ($urandom_range(40, 10)) @(negedge i_clk);
        else if (gap >= 80) repeat ($urandom_range(3, 1)) @(negedge i_clk);
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
        start  = 1'b1;
        i_item = it;
        p = predict_alert(it);
        pending_results.push_back(typed ? want : p);
        @(negedge i_clk);
        start  = 1'b0;
        i_item = t_item'(69'({$urandom, $urandom, $urandom}));
    endtask

    function automatic t_item mk(logic [1:0] op, logic [63:0] cs, bit m, bit e, bit l);
        t_item it;
        it.operation = op;
        it.callsign_chars = cs;
        it.is_military = m;
        it.is_emergency = e;
        it.last_in_batch = l;
        return it;
    endfunction

    function automatic logic [63:0] random_callsign();
        logic [63:0] v;
        string s;
        int pick, pos;
        pick = $urandom_range(9, 0);
        if (pick < 6) begin
            s = callsign_pool[$urandom_range(23, 0)];
            for (int k = 0; k < s.len(); k++)
                if ($urandom_range(3, 0) == 0 && s[k] >= "A" && s[k] <= "Z")
                    s[k] = s[k] + 8'h20;
            v = pack_name(s);
            if (s.len() < NAME_BYTES && $urandom_range(3, 0) == 0) begin
                pos = $urandom_range(s.len(), 0);
                v = (v & ((64'h1 << (8*pos)) - 1))
                    | ((v >> (8*pos)) << (8*pos + 8))
                    | (64'(($urandom_range(1, 0) ? 8'h20 : 8'h09)) << (8*pos));
            end
            return v;
        end
        v = {$urandom, $urandom};
        if (pick < 8) v = v & ((64'h1 << (8*$urandom_range(7, 0))) - 1);
        return v;
    endfunction

    initial begin
        #20ms;
        $display("== FAIL ==");
        $finish;
    end

    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_row;

    initial begin
        t_row    rows[$];
        t_item   it;
        int      r;
        watch_used = 0;
        ring_ptr = 0;
        batch_flag = 0;
        mil_en = 0;
        emg_en = 0;
        foreach (recent_ok[i]) recent_ok[i] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // alerts off, empty list: quiet result, empty name hashes to the basis
        rows.push_back('{mk(OP_CHECK, '0, 1, 1, 1), 1,
                         '{0, 0, 0, 0, 0, 5'd0, FNV_BASIS}});
        rows.push_back('{mk(OP_ADD, pack_name("ab c123"), 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_ADD, pack_name("ABC123"), 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_ADD, pack_name("AB1"), 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_ADD, pack_name("A1B2"), 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_ADD, pack_name("ZZZZ9999"), 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_ADD, pack_name("az\tyx"), 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_CHECK, pack_name("abc123"), 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_CHECK, pack_name("abc123"), 1, 1, 1), 0, '0});
        rows.push_back('{mk(OP_CHECK, pack_name("zzzz9999"), 0, 0, 1), 0, '0});
        rows.push_back('{mk(OP_CHECK, '1, 1, 1, 1), 0, '0});
        rows.push_back('{mk(OP_UNUSED, '1, 1, 1, 1), 0, '0});
        rows.push_back('{mk(OP_CLEAR, pack_name("ABC123"), 1, 1, 1), 0, '0});
        rows.push_back('{mk(OP_CHECK, pack_name("ABC123"), 1, 1, 1), 0, '0});
        foreach (rows[i]) send_word(rows[i].it, rows[i].typed, rows[i].want);
        rows.delete();

        set_enables(1, 1);
        rows.push_back('{mk(OP_CHECK, '0, 1, 0, 0), 0, '0});
        rows.push_back('{mk(OP_CHECK, '0, 0, 1, 1), 0, '0});
        rows.push_back('{mk(OP_CHECK, pack_name("DLH4"), 0, 1, 0), 0, '0});
        rows.push_back('{mk(OP_CHECK, pack_name("DLH4"), 1, 0, 1), 0, '0});
        rows.push_back('{mk(OP_CHECK, '1, 0, 0, 1), 0, '0});
        rows.push_back('{mk(OP_CHECK, 64'h0, 0, 0, 1), 0, '0});
        foreach (rows[i]) send_word(rows[i].it, rows[i].typed, rows[i].want);

        set_enables(1, 0);
        send_word(mk(OP_CHECK, pack_name("KLM7"), 1, 1, 1), 0, '0);
        set_enables(0, 1);
        send_word(mk(OP_CHECK, pack_name("KLM7x"), 1, 1, 1), 0, '0);
        set_enables(0, 0);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 200 == 199)
                set_enables(1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
            r = $urandom_range(99, 0);
            it = mk(r < 72 ? OP_CHECK : r < 92 ? OP_ADD : r < 97 ? OP_CLEAR : OP_UNUSED,
                    random_callsign(), 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)),
                    $urandom_range(5, 0) == 0);
            send_word(it, 0, '0);
        end

        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (150) @(negedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
